>>> sv/packet_loss_resend_requester_defines.svh
// assertion macros shared by the rtl
`ifndef PACKET_LOSS_RESEND_REQUESTER_DEFINES_SVH
`define PACKET_LOSS_RESEND_REQUESTER_DEFINES_SVH

// condition implies consequence in the same cycle
`define PLRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PLRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/plrr_pkg.sv
`default_nettype none

package plrr_pkg;

  localparam logic [7:0]  DATA_TYPE         = 8'h33;
  localparam logic [15:0] TOTAL_PACKETS_RST = 16'd39;
  localparam logic [7:0]  GAP_LIMIT_RST     = 8'd3;
  localparam int          QUEUE_DEPTH_DEF   = 4;

  typedef enum logic {
    CFG_TOTAL_PACKETS = 1'b0,
    CFG_GAP_LIMIT     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic        last;
    logic [31:0] total;
    logic [7:0]  count;
    logic [15:0] first;
    logic [23:0] stamp;
    logic [7:0]  camera;
  } plrr_req_t;

  typedef struct packed {
    logic [1:0] num;
    plrr_req_t  req0;
    plrr_req_t  req1;
  } plrr_push_t;

endpackage

`default_nettype wire

>>> sv/packet_loss_resend_requester.sv
// Packet loss resend requester. Each input request is one image packet
// header (type in in_tuser, camera, frame stamp and packet number in
// in_tdata); each output request asks for a run of lost packets to be sent
// again, with a running total of packets asked for and tlast on the last
// request a header causes. A header may cause zero, one or two requests.
// A header is taken into an input register, evaluated against the kept
// camera, stamp and number once the queue has room for two results, and
// its requests are written into a small result queue (QUEUE_DEPTH
// entries) whose head drives out_*. One header is accepted every cycle
// while the queue has room for two results; its requests pass the input
// register and the queue before out_tvalid rises. Two requests from one
// header need two transfers on the single output port, which sets the
// sustained rate. The user must write configuration through cfg_we/
// cfg_addr/cfg_wdata only while no header is in flight (not enforced).
`default_nettype none

module packet_loss_resend_requester
  import plrr_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // camera_id, frame_stamp, packet_number
  input  wire logic [7:0]  in_tuser,  // packet_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata, // req_camera, req_stamp, req_first, req_count,
                                      // resend_total
  output logic             out_tlast
);

  logic [15:0] total_packets_r, total_packets_nxt;
  logic [7:0]  gap_limit_r, gap_limit_nxt;
  logic        in_v_r, in_v_nxt;
  logic [7:0]  type_r;
  logic [7:0]  camera_r;
  logic [23:0] stamp_r;
  logic [15:0] number_r;
  logic        room2, go;
  plrr_push_t  push;
  plrr_req_t   head;

  always_comb begin
    total_packets_nxt = total_packets_r;
    gap_limit_nxt     = gap_limit_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_TOTAL_PACKETS: total_packets_nxt = cfg_wdata;
        CFG_GAP_LIMIT:     gap_limit_nxt     = cfg_wdata[7:0];
        default:           ;
      endcase
    end
  end

  assign go        = in_v_r && room2;
  assign in_tready = !in_v_r || go;
  assign in_v_nxt  = in_tready ? in_tvalid : in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_packets_r <= TOTAL_PACKETS_RST;
      gap_limit_r     <= GAP_LIMIT_RST;
      in_v_r          <= 1'b0;
    end else begin
      total_packets_r <= total_packets_nxt;
      gap_limit_r     <= gap_limit_nxt;
      in_v_r          <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      type_r   <= in_tuser;
      camera_r <= in_tdata[7:0];
      stamp_r  <= in_tdata[31:8];
      number_r <= in_tdata[47:32];
    end
  end

  plrr_eval u_eval (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .packet_type   (type_r),
    .camera_id     (camera_r),
    .frame_stamp   (stamp_r),
    .packet_number (number_r),
    .total_packets (total_packets_r),
    .gap_limit     (gap_limit_r),
    .push          (push)
  );

  plrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_req   (head)
  );

  assign out_tdata = {head.total, head.count, head.first, head.stamp, head.camera};
  assign out_tlast = head.last;

endmodule

`default_nettype wire

>>> sv/plrr_eval.sv
`default_nettype none

`include "packet_loss_resend_requester_defines.svh"

module plrr_eval
  import plrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [7:0]  packet_type,
  input  wire logic [7:0]  camera_id,
  input  wire logic [23:0] frame_stamp,
  input  wire logic [15:0] packet_number,
  input  wire logic [15:0] total_packets,
  input  wire logic [7:0]  gap_limit,
  output plrr_push_t       push
);

  logic        seen_first_r, seen_first_nxt;
  logic [7:0]  prev_camera_r, prev_camera_nxt;
  logic [23:0] prev_stamp_r, prev_stamp_nxt;
  logic [15:0] prev_number_r, prev_number_nxt;
  logic [31:0] requested_sum_r, requested_sum_nxt;

  logic        is_data, active, cam_chg;
  logic [16:0] tail_diff, head_diff;
  logic [17:0] gap_diff;
  logic        tail_ok, head_ok, gap_ok;
  logic        a_ok, b_ok;
  plrr_req_t   req_a, req_b;
  logic [31:0] sum_a, base_b, sum_b;

  assign is_data = (packet_type == DATA_TYPE);
  assign active  = go && seen_first_r && is_data;
  assign cam_chg = (camera_id != prev_camera_r);

  assign tail_diff = {1'b0, total_packets} - {1'b0, prev_number_r};
  assign head_diff = {1'b0, packet_number} - 17'd1;
  assign gap_diff  = {2'b00, packet_number} - {2'b00, prev_number_r} - 18'd1;

  assign tail_ok = !tail_diff[16] && (tail_diff != 17'd0)
                   && (tail_diff[15:0] < {8'd0, gap_limit});
  assign head_ok = !head_diff[16] && (head_diff != 17'd0)
                   && (head_diff[15:0] < {8'd0, gap_limit});
  assign gap_ok  = !gap_diff[17] && (gap_diff != 18'd0)
                   && (gap_diff[16:0] < {9'd0, gap_limit});

  always_comb begin
    req_a = '0;
    req_b = '0;
    if (cam_chg) begin
      a_ok         = active && tail_ok;
      b_ok         = active && head_ok;
      req_a.camera = prev_camera_r;
      req_a.stamp  = prev_stamp_r;
      req_a.first  = prev_number_r + 16'd1;
      req_a.count  = tail_diff[7:0];
      req_b.camera = camera_id;
      req_b.stamp  = frame_stamp;
      req_b.first  = 16'd1;
      req_b.count  = head_diff[7:0];
    end else begin
      a_ok         = active && (packet_number != 16'd0) && gap_ok;
      b_ok         = 1'b0;
      req_a.camera = camera_id;
      req_a.stamp  = frame_stamp;
      req_a.first  = prev_number_r + 16'd1;
      req_a.count  = gap_diff[7:0];
    end
    sum_a       = requested_sum_r + {24'd0, req_a.count};
    base_b      = a_ok ? sum_a : requested_sum_r;
    sum_b       = base_b + {24'd0, req_b.count};
    req_a.total = sum_a;
    req_b.total = sum_b;
  end

  always_comb begin
    push = '0;
    if (a_ok) begin
      push.num  = b_ok ? 2'd2 : 2'd1;
      push.req0 = req_a;
      push.req1 = req_b;
    end else if (b_ok) begin
      push.num  = 2'd1;
      push.req0 = req_b;
    end
    push.req0.last = (push.num == 2'd1);
    push.req1.last = 1'b1;
  end

  always_comb begin
    seen_first_nxt    = seen_first_r;
    prev_camera_nxt   = prev_camera_r;
    prev_stamp_nxt    = prev_stamp_r;
    prev_number_nxt   = prev_number_r;
    requested_sum_nxt = requested_sum_r;
    if (go) begin
      seen_first_nxt = 1'b1;
      if (is_data) begin
        prev_camera_nxt = camera_id;
        prev_stamp_nxt  = frame_stamp;
        prev_number_nxt = packet_number;
      end
      if (b_ok) begin
        requested_sum_nxt = sum_b;
      end else if (a_ok) begin
        requested_sum_nxt = sum_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r    <= 1'b0;
      prev_camera_r   <= '0;
      prev_stamp_r    <= '0;
      prev_number_r   <= '0;
      requested_sum_r <= '0;
    end else begin
      seen_first_r    <= seen_first_nxt;
      prev_camera_r   <= prev_camera_nxt;
      prev_stamp_r    <= prev_stamp_nxt;
      prev_number_r   <= prev_number_nxt;
      requested_sum_r <= requested_sum_nxt;
    end
  end

  `PLRR_ASSERT_NOW(a_two_last, push.num == 2'd2, !push.req0.last && push.req1.last, "two requests: only second is last")
  `PLRR_ASSERT_NOW(a_first_quiet, go && !seen_first_r, push.num == 2'd0, "first header made a request")
  `PLRR_ASSERT_NOW(a_idle_quiet, !go, push.num == 2'd0, "request without a header")
  `PLRR_ASSERT_NEXT(a_state_load, go && is_data, prev_number_r == $past(packet_number), "kept number not loaded")

endmodule

`default_nettype wire

>>> sv/plrr_queue.sv
`default_nettype none

`include "packet_loss_resend_requester_defines.svh"

module plrr_queue
  import plrr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire plrr_push_t push,
  output logic            room2,
  output logic            out_valid,
  input  wire logic       out_ready,
  output plrr_req_t       out_req
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);

  plrr_req_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_valid = (count_r != '0);
  assign out_req   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= CNT_W'(DEPTH - 2));
  assign wr_ptr_p1 = ptr_inc(wr_ptr_r);

  always_comb begin
    case (push.num)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push.num) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.req0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.req1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `PLRR_ASSERT_NOW(a_cnt_range, 1'b1, count_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `PLRR_ASSERT_NOW(a_no_overflow, push.num != 2'd0, CNT_W'(push.num) + count_r <= CNT_W'(DEPTH), "queue overflow")
  `PLRR_ASSERT_NEXT(a_drain, count_r == CNT_W'(1) && pop && push.num == 2'd0, !out_valid, "queue not empty after last pop")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
  import plrr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int LONG_HOLD = 400;

  class resend_scoreboard;
    bit          seen_first;
    logic [7:0]  prev_cam = 8'h0;
    logic [23:0] prev_stamp = 24'h0;
    logic [15:0] prev_num = 16'h0;
    logic [31:0] sum = 32'h0;
    logic [15:0] total_pkts = TOTAL_PACKETS_RST;
    logic [7:0]  gap_lim = GAP_LIMIT_RST;
    plrr_req_t   expected_reqs[$];
    int          errors;

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      if (r == CFG_TOTAL_PACKETS) begin
        total_pkts = v;
      end else begin
        gap_lim = v[7:0];
      end
    endfunction

    function int pending();
      return expected_reqs.size();
    endfunction

    function bit gap_ok(int n);
      return n > 0 && n < int'(gap_lim);
    endfunction

    function void push_req(logic [7:0] c, logic [23:0] s, logic [15:0] f, int n);
      plrr_req_t r;
      sum = sum + 32'(n);
      r.camera = c;
      r.stamp = s;
      r.first = f;
      r.count = n[7:0];
      r.total = sum;
      r.last = 1'b0;
      expected_reqs.insert(expected_reqs.size(), r);
    endfunction

    // one accepted header
    function void note_header(logic [7:0] kind, logic [7:0] cam, logic [23:0] stamp,
                              logic [15:0] num);
      int n;
      int base;
      base = expected_reqs.size();
      if (!seen_first) begin
        seen_first = 1'b1;
        if (kind == DATA_TYPE) begin
          prev_cam = cam;
          prev_stamp = stamp;
          prev_num = num;
        end
        return;
      end
      if (kind != DATA_TYPE) return;
      if (cam != prev_cam) begin
        // lost tail of the old frame, then lost head of the new one
        n = int'(total_pkts) - int'(prev_num);
        if (gap_ok(n)) push_req(prev_cam, prev_stamp, prev_num + 16'd1, n);
        n = int'(num) - 1;
        if (gap_ok(n)) push_req(cam, stamp, 16'd1, n);
      end else if (num != 16'd0) begin
        n = int'(num) - int'(prev_num) - 1;
        if (gap_ok(n)) push_req(cam, stamp, prev_num + 16'd1, n);
      end
      if (expected_reqs.size() > base) expected_reqs[$].last = 1'b1;
      prev_cam = cam;
      prev_stamp = stamp;
      prev_num = num;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 50) begin
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
      end
      errors++;
    endtask

    task check_request(logic [87:0] data, logic last);
      plrr_req_t want;
      if (expected_reqs.size() == 0) begin
        report("unexpected request, camera", 32'(data[7:0]), 32'h0);
        return;
      end
      want = expected_reqs.pop_front();
      if (data[7:0] !== want.camera) report("req_camera", 32'(data[7:0]), 32'(want.camera));
      if (data[31:8] !== want.stamp) report("req_stamp", 32'(data[31:8]), 32'(want.stamp));
      if (data[47:32] !== want.first) report("req_first", 32'(data[47:32]), 32'(want.first));
      if (data[55:48] !== want.count) report("req_count", 32'(data[55:48]), 32'(want.count));
      if (data[87:56] !== want.total) report("resend_total", data[87:56], want.total);
      if (last !== want.last) report("last_of_run", 32'(last), 32'(want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_addr = CFG_TOTAL_PACKETS;
  logic [15:0] cfg_wdata = 16'h0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = 48'h0;  // camera_id, frame_stamp, packet_number
  logic [7:0]  in_tuser = 8'h0;   // packet_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;         // req_camera, req_stamp, req_first, req_count, resend_total
  logic        out_tlast;

  resend_scoreboard sb = new();

  int          cycles = 0;
  int          burst_left = 0;
  bit          hold_pending = 1'b0;
  int          hold_cnt = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          cur_total = TOTAL_PACKETS_RST;
  int          cur_gap = GAP_LIMIT_RST;
  logic [7:0]  cams[4];
  logic [7:0]  cur_cam = 8'h0;
  logic [23:0] cur_stamp = 24'h0;
  logic [15:0] cur_num = 16'h0;

  packet_loss_resend_requester dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: long hold-off on demand, otherwise changing stall patterns
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_pending) begin
      hold_pending = 1'b0;
      hold_cnt <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 2);
        rx_left <= $urandom_range(5, 60);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_request(out_tdata, out_tlast);
  end

  task send(input logic [7:0] kind, input logic [7:0] cam, input logic [23:0] stamp,
            input logic [15:0] num);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {num, stamp, cam};
    do @(posedge clk); while (!in_tready);
    sb.note_header(kind, cam, stamp, num);
    burst_left--;
  endtask

  task wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task configure(input logic [15:0] total, input logic [7:0] gap);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_TOTAL_PACKETS;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_addr <= CFG_GAP_LIMIT;
    cfg_wdata <= {8'h00, gap};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_TOTAL_PACKETS, total);
    sb.set_reg(CFG_GAP_LIMIT, {8'h00, gap});
    cur_total = total;
    cur_gap = gap;
  endtask

  task new_frame();
    cur_cam = ($urandom_range(0, 15) == 0) ? 8'($urandom) : cams[$urandom_range(0, 3)];
    cur_stamp = 24'($urandom);
    cur_num = 16'($urandom_range(0, cur_gap + 1));
  endtask

  // mostly frames with small losses, some noise and broken numbering
  task random_header();
    int r;
    int s;
    logic [7:0] kind;
    r = $urandom_range(0, 99);
    kind = DATA_TYPE;
    if (r < 6) begin
      send(8'($urandom), 8'($urandom), 24'($urandom), 16'($urandom));
      return;
    end
    if (r < 10) begin
      kind = 8'($urandom);
      if (kind == DATA_TYPE) kind = 8'h34;
    end else if (r < 18) begin
      new_frame();
    end else if (r < 24) begin
      if ($urandom_range(0, 1) == 0) begin
        cur_num = 16'($urandom);
      end else if (cur_total > cur_gap) begin
        cur_num = 16'(cur_total - $urandom_range(0, cur_gap));
      end else begin
        cur_num = 16'($urandom_range(0, cur_total));
      end
    end else begin
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(2, cur_gap + 1) : 1;
      if (int'(cur_num) + s > cur_total) begin
        new_frame();
      end else begin
        cur_num = 16'(int'(cur_num) + s);
      end
    end
    send(kind, cur_cam, cur_stamp, cur_num);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings; first header is not data
    send(8'h00, 8'hff, 24'hffffff, 16'hffff);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd2);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd0);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd3);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd6);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd9);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd12);
    send(DATA_TYPE, 8'h00, 24'h000000, 16'd16);
    send(DATA_TYPE, 8'h01, 24'h123456, 16'd3);
    wait_idle();
    configure(16'd40, 8'd255);
    send(DATA_TYPE, 8'h01, 24'h123456, 16'd38);
    send(DATA_TYPE, 8'h02, 24'hffffff, 16'd5);
    send(8'h32, 8'h02, 24'h000000, 16'd100);
    send(8'hff, 8'h00, 24'h000000, 16'd0);
    send(DATA_TYPE, 8'h02, 24'hffffff, 16'd4);
    send(DATA_TYPE, 8'h02, 24'hffffff, 16'd4);
    send(DATA_TYPE, 8'hff, 24'h000001, 16'hffff);
    send(DATA_TYPE, 8'hff, 24'h000001, 16'd0);
    send(DATA_TYPE, 8'hff, 24'h000001, 16'd255);
    send(DATA_TYPE, 8'h00, 24'hab_cdef, 16'd256);
    send(DATA_TYPE, 8'h00, 24'hab_cdef, 16'd1000);
    wait_idle();
    configure(16'd1, 8'd2);
    send(DATA_TYPE, 8'h05, 24'h5a5a5a, 16'd0);
    send(DATA_TYPE, 8'h06, 24'ha5a5a5, 16'd2);
    send(DATA_TYPE, 8'h06, 24'ha5a5a5, 16'd4);
    wait_idle();
    configure(16'hffff, 8'd255);
    send(DATA_TYPE, 8'h06, 24'h000100, 16'hfffe);
    send(DATA_TYPE, 8'h07, 24'h800000, 16'd1);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: configure(16'($urandom_range(20, 80)), 8'($urandom_range(4, 40)));
        1: configure(16'hffff, 8'd255);
        2: configure(16'd1, 8'd2);
        3: configure(16'($urandom_range(1, 65535)), 8'($urandom_range(2, 255)));
        default: configure(16'($urandom_range(10, 300)), 8'($urandom_range(2, 20)));
      endcase
      foreach (cams[i]) cams[i] = 8'($urandom);
      new_frame();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 0 || p == 3) && i == 20) hold_pending = 1'b1;
        if (p == 4 && i == 80) wait_idle();
        random_header();
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
